### design/eg_pkg.sv
// Package for the Euclid GCD block: default width and the command and status
// bundles between the controller and the datapath. No dependencies.
package eg_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture a new operand pair
        logic step;       // one restoring division step
        logic next_iter;  // divisor becomes dividend, remainder becomes divisor
        logic out_write;  // move the result into the output register
    } dp_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic load_error;  // operand pair on the inputs is invalid
        logic rem_zero;    // remainder register is zero
        logic out_busy;    // output register holds a transaction that is stalled
    } dp_status_t;

endpackage

### design/euclid_gcd.sv
// Euclid GCD top level: one transaction in, greatest common divisor out.
// An invalid pair goes straight to the result; otherwise the divider runs one pass
// per Euclid iteration until the remainder is zero.
// Throughput: one transaction at a time, set by the bit-serial divider that
// produces one quotient bit per cycle.
// Reset: rst_n (asynchronous, active low) idles the controller and empties the output register.
module euclid_gcd #(
    parameter int DATA_WIDTH = eg_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [DATA_WIDTH-1:0] operand_a,
    input  logic [DATA_WIDTH-1:0] operand_b,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DATA_WIDTH-2:0] gcd_value,
    output logic                  input_error
);
    import eg_pkg::*;

    // The controller and the datapath talk only through these two bundles.
    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller takes a transaction only while idle. It runs the divider
    // for one full pass per Euclid iteration, checks the remainder, and then
    // either swaps the registers for the next pass or writes the result.
    eg_controller #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    // The datapath holds the dividend, divisor and remainder, plus an output
    // register, so a new transaction can be accepted while a result waits.
    eg_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .operand_a   (operand_a),
        .operand_b   (operand_b),
        .cmd         (cmd),
        .status      (status),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .gcd_value   (gcd_value),
        .input_error (input_error)
    );

`ifndef SYNTHESIS
    // An accepted transaction keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted but block not busy afterwards");

    // An error result carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && input_error) |-> (gcd_value == '0))
        else $error("error result with nonzero value");

    // A valid result is never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !input_error) |-> (gcd_value != '0))
        else $error("valid result with zero value");
`endif

endmodule

### design/eg_datapath.sv
// Datapath of the Euclid GCD block: operand registers, a bit-serial
// restoring divider and the output register. Depends on eg_pkg.
module eg_datapath #(
    parameter int DATA_WIDTH = eg_pkg::DATA_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [DATA_WIDTH-1:0]   operand_a,
    input  logic [DATA_WIDTH-1:0]   operand_b,
    input  eg_pkg::dp_cmd_t         cmd,
    output eg_pkg::dp_status_t      status,
    input  logic                    out_stall,
    output logic                    out_valid,
    output logic [DATA_WIDTH-2:0]   gcd_value,
    output logic                    input_error
);
    import eg_pkg::*;

    localparam int DW = DATA_WIDTH - 1;

    logic [DW-1:0] dvd_reg;
    logic [DW-1:0] div_reg;
    logic [DW-1:0] rem_reg;
    logic          err_reg;
    logic          out_valid_reg;
    logic [DW-1:0] gcd_reg;
    logic          err_out_reg;

    logic [DW-1:0] a_mag;
    logic [DW-1:0] b_mag;
    logic          a_bad;
    logic          b_bad;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;
    logic [DW-1:0] rem_next;

    assign a_mag = operand_a[DW-1:0];
    assign b_mag = operand_b[DW-1:0];
    assign a_bad = operand_a[DW] || (a_mag == '0);
    assign b_bad = operand_b[DW] || (b_mag == '0);

    // One restoring step: bring down the next dividend bit and subtract if it fits.
    assign trial    = {rem_reg, dvd_reg[DW-1]};
    assign diff     = trial - {1'b0, div_reg};
    assign fits     = (trial >= {1'b0, div_reg});
    assign rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            err_reg <= a_bad || b_bad;
            rem_reg <= '0;
            if (a_mag >= b_mag)
            begin
                dvd_reg <= a_mag;
                div_reg <= b_mag;
            end
            else
            begin
                dvd_reg <= b_mag;
                div_reg <= a_mag;
            end
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
        end
        else if (cmd.next_iter)
        begin
            dvd_reg <= div_reg;
            div_reg <= rem_reg;
            rem_reg <= '0;
        end
        if (cmd.out_write)
        begin
            gcd_reg     <= err_reg ? '0 : div_reg;
            err_out_reg <= err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_write)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.load_error = a_bad || b_bad;
    assign status.rem_zero   = (rem_reg == '0);
    assign status.out_busy   = out_valid_reg && out_stall;

    assign out_valid   = out_valid_reg;
    assign gcd_value   = gcd_reg;
    assign input_error = err_out_reg;

endmodule

### design/eg_controller.sv
// Controller of the Euclid GCD block: sequences loads, division steps,
// Euclid iterations and the result write. Depends on eg_pkg.
module eg_controller #(
    parameter int DATA_WIDTH = eg_pkg::DATA_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output eg_pkg::dp_cmd_t     cmd,
    input  eg_pkg::dp_status_t  status
);
    import eg_pkg::*;

    localparam int DW = DATA_WIDTH - 1;
    localparam int CW = $clog2(DW);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIVIDE = 4'b0010,
        ST_CHECK  = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    count_next = '0;
                    state_next = status.load_error ? ST_RESULT : ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.step   = 1'b1;
                count_next = count_reg + 1'b1;
                if (count_reg == CW'(DW - 1))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.rem_zero)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.next_iter = 1'b1;
                    count_next    = '0;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_RESULT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_write = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule
